/* rtl/acl_pkg.sv */
// ----------------------------------------------------------------------------
// acl_pkg: shared types and constants
// Types, operation codes and controller/datapath links for the rule classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package acl_pkg;

  // table depth; result fields are sized for 64 rules
  localparam int unsigned MAX_RULES = 64;
  localparam int unsigned AW = $clog2(MAX_RULES);

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef enum logic [1:0] {
    OP_CHECK  = 2'd0,
    OP_APPEND = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [7:0]  src_prefix_len;
    logic [7:0]  dst_prefix_len;
    logic [7:0]  protocol;
    logic [31:0] src_ports;
    logic [31:0] dst_ports;
    logic [1:0]  flags;
    logic [5:0]  rule_index;
  } req_t;

  typedef struct packed {
    logic       status;
    logic       permit;
    logic       deny_hit;
    logic [5:0] deny_index;
    logic [6:0] rules_held;
  } rsp_t;

  // one stored rule, one memory word
  typedef struct packed {
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [7:0]  src_len;
    logic [7:0]  dst_len;
    logic [7:0]  proto;
    logic        ports_en;
    logic        allow;
    logic [31:0] src_ports;
    logic [31:0] dst_ports;
  } rule_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture request
    logic rd_en;   // read rule at rd_addr
    logic wr_new;  // write request rule at wr_addr
    logic wr_mv;   // write last read rule at wr_addr
    logic cmp;     // compare last read rule
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic match;   // registered rule matches packet
    logic deny;    // matched rule is a deny rule
  } dp_sts_t;

  function automatic logic [63:0] hi_mask(input logic [7:0] len);
    logic [7:0] l;
    l = (len > 8'd128) ? 8'd128 : len;
    if (l == 8'd0) return '0;
    if (l >= 8'd64) return '1;
    return ~64'd0 << (7'd64 - l[6:0]);
  endfunction

  function automatic logic [63:0] lo_mask(input logic [7:0] len);
    logic [7:0] l;
    l = (len > 8'd128) ? 8'd128 : len;
    if (l <= 8'd64) return '0;
    if (l >= 8'd128) return '1;
    return ~64'd0 << (8'd128 - l);
  endfunction

endpackage

`default_nettype wire

/* rtl/ipv6_acl_rule_classifier.sv */
// ----------------------------------------------------------------------------
// ipv6_acl_rule_classifier: ordered IPv6 ACL with first-deny match
// Controller plus rule memory datapath; one result beat per command.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy low; its one result beat
// appears with done_o for one cycle and cannot be stalled. A check reads one
// rule at a time from the rule memory, passing through a read, a compare and
// a test state for each rule; append, clear and a rejected delete go straight
// to the done state; delete shifts one rule per cycle down over the deleted one.
`default_nettype none

module ipv6_acl_rule_classifier (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  acl_pkg::req_t       req_i,
  output logic                done_o,
  output acl_pkg::rsp_t       rsp_o,
  input  wire logic           cfg_we_i,
  input  wire logic [6:0]     cfg_wdata_i
);
  import acl_pkg::*;

  logic [6:0]    limit_q;
  dp_cmd_t       cmd;
  dp_sts_t       sts;
  logic [AW-1:0] rd_addr, wr_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= 7'd64;
    else if (cfg_we_i) limit_q <= cfg_wdata_i;
  end

  acl_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .busy, .req_i, .limit_i(limit_q),
    .cmd_o(cmd), .rd_addr_o(rd_addr), .wr_addr_o(wr_addr),
    .sts_i(sts), .done_o, .rsp_o
  );

  acl_datapath u_dp (
    .clk_i, .rst_ni, .req_i, .cmd_i(cmd),
    .rd_addr_i(rd_addr), .wr_addr_i(wr_addr), .sts_o(sts)
  );

endmodule

`default_nettype wire

/* rtl/acl_datapath.sv */
// ----------------------------------------------------------------------------
// acl_datapath: rule memory and one-rule comparator
// Holds the rule table and compares one read rule per cycle against the packet when cmp is set.
// ----------------------------------------------------------------------------
`default_nettype none

module acl_datapath (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  acl_pkg::req_t               req_i,
  input  acl_pkg::dp_cmd_t            cmd_i,
  input  wire logic [acl_pkg::AW-1:0] rd_addr_i,
  input  wire logic [acl_pkg::AW-1:0] wr_addr_i,
  output acl_pkg::dp_sts_t            sts_o
);
  import acl_pkg::*;

  rule_t mem_q [MAX_RULES];
  rule_t rd_q;
  req_t  req_q;
  logic  match_q, deny_q;

  logic [15:0] sp, dp;
  logic        m;
  rule_t       new_rule;

  always_comb begin
    new_rule = '{src_hi: req_q.src_addr_hi, src_lo: req_q.src_addr_lo,
                 dst_hi: req_q.dst_addr_hi, dst_lo: req_q.dst_addr_lo,
                 src_len: req_q.src_prefix_len, dst_len: req_q.dst_prefix_len,
                 proto: req_q.protocol, ports_en: req_q.flags[0],
                 allow: req_q.flags[1], src_ports: req_q.src_ports,
                 dst_ports: req_q.dst_ports};
  end

  always_comb begin
    if (req_q.flags[0] && (req_q.protocol == PROTO_TCP || req_q.protocol == PROTO_UDP)) begin
      sp = req_q.src_ports[15:0];
      dp = req_q.dst_ports[15:0];
    end else begin
      sp = '0;
      dp = '0;
    end
    m = (((req_q.src_addr_hi ^ rd_q.src_hi) & hi_mask(rd_q.src_len)) == '0)
     && (((req_q.src_addr_lo ^ rd_q.src_lo) & lo_mask(rd_q.src_len)) == '0)
     && (((req_q.dst_addr_hi ^ rd_q.dst_hi) & hi_mask(rd_q.dst_len)) == '0)
     && (((req_q.dst_addr_lo ^ rd_q.dst_lo) & lo_mask(rd_q.dst_len)) == '0);
    if (rd_q.ports_en) begin
      if (rd_q.proto != 8'd0 && rd_q.proto != req_q.protocol) m = 1'b0;
      if (sp < rd_q.src_ports[31:16] || sp > rd_q.src_ports[15:0]) m = 1'b0;
      if (dp < rd_q.dst_ports[31:16] || dp > rd_q.dst_ports[15:0]) m = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.rd_en) rd_q <= mem_q[rd_addr_i];
    if (cmd_i.wr_new) mem_q[wr_addr_i] <= new_rule;
    else if (cmd_i.wr_mv) mem_q[wr_addr_i] <= rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      deny_q  <= 1'b0;
    end else if (cmd_i.cmp) begin
      match_q <= m;
      deny_q  <= ~rd_q.allow;
    end
  end

  assign sts_o = '{match: match_q, deny: deny_q};

  a_no_dual_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.wr_new && cmd_i.wr_mv)) else $error("two writes in one cycle");
  a_load_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !cmd_i.cmp) else $error("compare during load");
  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_new || cmd_i.wr_mv) |-> (32'(wr_addr_i) < MAX_RULES))
    else $error("write beyond table");

endmodule

`default_nettype wire

/* rtl/acl_ctrl.sv */
// ----------------------------------------------------------------------------
// acl_ctrl: operation sequencer
// Runs check scans, appends, shifting deletes and clears; builds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module acl_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  acl_pkg::req_t               req_i,
  input  wire logic [6:0]             limit_i,
  output acl_pkg::dp_cmd_t            cmd_o,
  output logic [acl_pkg::AW-1:0]      rd_addr_o,
  output logic [acl_pkg::AW-1:0]      wr_addr_o,
  input  acl_pkg::dp_sts_t            sts_i,
  output logic                        done_o,
  output acl_pkg::rsp_t               rsp_o
);
  import acl_pkg::*;

  localparam logic [AW:0] MAXR = (AW+1)'(MAX_RULES);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CMP, S_TEST, S_SHIFT, S_DONE
  } state_e;

  state_e       state_q;
  logic [AW:0]  cnt_q, idx_q;
  logic [1:0]   op_q;
  logic         status_q, hit_q;
  logic [AW-1:0] didx_q;
  logic [AW:0]  cap;
  logic         accept;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign cap    = (32'(limit_i) > MAX_RULES) ? MAXR : (AW+1)'(limit_i);

  always_comb begin
    cmd_o     = '0;
    rd_addr_o = idx_q[AW-1:0];
    wr_addr_o = cnt_q[AW-1:0];
    cmd_o.load = accept;
    unique case (state_q)
      S_RD:    cmd_o.rd_en = 1'b1;
      S_CMP:   cmd_o.cmp   = 1'b1;
      S_TEST:  cmd_o.rd_en = (op_q == OP_DELETE);
      S_SHIFT: begin
        cmd_o.wr_mv = 1'b1;
        wr_addr_o   = AW'(idx_q - 1'b1);
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = AW'(idx_q + 1'b1);
      end
      S_DONE:  cmd_o.wr_new = (op_q == OP_APPEND) && !status_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      idx_q    <= '0;
      op_q     <= OP_CHECK;
      status_q <= 1'b0;
      hit_q    <= 1'b0;
      didx_q   <= '0;
      done_o   <= 1'b0;
      rsp_o    <= '0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        S_IDLE: if (accept) begin
          op_q     <= req_i.operation;
          status_q <= 1'b0;
          hit_q    <= 1'b0;
          didx_q   <= '0;
          unique case (req_i.operation)
            OP_CHECK: begin
              idx_q   <= '0;
              state_q <= (cnt_q == '0) ? S_DONE : S_RD;
            end
            OP_APPEND: begin
              status_q <= (cnt_q >= cap);
              state_q  <= S_DONE;
            end
            OP_DELETE: begin
              if ((AW+1)'(req_i.rule_index) >= cnt_q) begin
                status_q <= 1'b1;
                state_q  <= S_DONE;
              end else begin
                idx_q   <= (AW+1)'(req_i.rule_index) + 1'b1;
                state_q <= S_TEST;
              end
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_RD:  state_q <= S_CMP;
        S_CMP: state_q <= S_TEST;
        S_TEST: begin
          if (op_q == OP_CHECK) begin
            if (sts_i.match && sts_i.deny) begin
              hit_q   <= 1'b1;
              didx_q  <= idx_q[AW-1:0];
              state_q <= S_DONE;
            end else if (idx_q + 1'b1 >= cnt_q) begin
              state_q <= S_DONE;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= S_RD;
            end
          end else begin
            // delete: first pull entry idx into the read register
            if (idx_q >= cnt_q) state_q <= S_DONE;
            else state_q <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          // entry idx moves down to idx-1 while entry idx+1 is fetched
          state_q <= S_SHIFT;
          idx_q   <= idx_q + 1'b1;
          if (idx_q + 1'b1 >= cnt_q) state_q <= S_DONE;
        end
        S_DONE: begin
          logic [AW:0] n;
          n = cnt_q;
          unique case (op_q)
            OP_APPEND: if (!status_q) n = cnt_q + 1'b1;
            OP_DELETE: if (!status_q) n = cnt_q - 1'b1;
            OP_CLEAR:  n = '0;
            default: ;
          endcase
          cnt_q  <= n;
          done_o <= 1'b1;
          rsp_o  <= '{status: status_q, permit: (op_q == OP_CHECK) && !hit_q,
                      deny_hit: hit_q, deny_index: 6'(didx_q), rules_held: 7'(n)};
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= MAX_RULES) else $error("count overflow");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result held two cycles");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> state_q == S_IDLE) else $error("result while busy");

endmodule

`default_nettype wire

/* tb/sv/ipv6_acl_rule_classifier_test.sv */
// ----------------------------------------------------------------------------
// ipv6_acl_rule_classifier_test: self-checking bench for the IPv6 ACL
// Commands go in through start/busy. A model of the rule table predicts
// every result beat, and the monitor checks each beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipv6_acl_rule_classifier_test;
  import acl_pkg::*;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  req_t       req_i;
  logic       done_o;
  rsp_t       rsp_o;
  logic       cfg_we_i;
  logic [6:0] cfg_wdata_i;

  ipv6_acl_rule_classifier u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .done_o(done_o), .rsp_o(rsp_o), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Shadow copy of the rule table.
  rule_t      acl_tbl[MAX_RULES];
  int         acl_count;
  logic [6:0] acl_limit;

  req_t cmd_q[$];
  rsp_t rsp_q[$];
  int   n_errors;
  bit   quiet;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    n_errors++;
  endtask

  function automatic bit prefix_hit(input logic [63:0] ah, al, bh, bl, input logic [7:0] len);
    logic [63:0] mh, ml;
    int          l;
    l  = (len > 128) ? 128 : len;
    mh = (l == 0) ? 64'd0 : (l >= 64) ? '1 : ~64'd0 << (64 - l);
    ml = (l <= 64) ? 64'd0 : (l >= 128) ? '1 : ~64'd0 << (128 - l);
    return (((ah ^ bh) & mh) == 0) && (((al ^ bl) & ml) == 0);
  endfunction

  function automatic bit rule_hit(input rule_t r, input req_t p, input logic [15:0] sp, dp);
    if (!prefix_hit(p.src_addr_hi, p.src_addr_lo, r.src_hi, r.src_lo, r.src_len)) return 0;
    if (!prefix_hit(p.dst_addr_hi, p.dst_addr_lo, r.dst_hi, r.dst_lo, r.dst_len)) return 0;
    if (!r.ports_en) return 1;
    if (r.proto != 0 && r.proto != p.protocol) return 0;
    if (sp < r.src_ports[31:16] || sp > r.src_ports[15:0]) return 0;
    if (dp < r.dst_ports[31:16] || dp > r.dst_ports[15:0]) return 0;
    return 1;
  endfunction

  function automatic rsp_t classify(input req_t c);
    rsp_t        r;
    logic [15:0] sp, dp;
    int          capacity;
    rule_t       nr;
    r = '0;
    capacity = (acl_limit > MAX_RULES) ? MAX_RULES : acl_limit;
    case (op_e'(c.operation))
      OP_CHECK: begin
        sp = '0;
        dp = '0;
        if (c.flags[0] && (c.protocol == PROTO_TCP || c.protocol == PROTO_UDP)) begin
          sp = c.src_ports[15:0];
          dp = c.dst_ports[15:0];
        end
        r.permit = 1'b1;
        for (int i = 0; i < acl_count; i++) begin
          if (rule_hit(acl_tbl[i], c, sp, dp) && !acl_tbl[i].allow) begin
            r.permit     = 1'b0;
            r.deny_hit   = 1'b1;
            r.deny_index = i[5:0];
            break;
          end
        end
      end
      OP_APPEND: begin
        if (acl_count >= capacity) r.status = 1'b1;
        else begin
          nr.src_hi = c.src_addr_hi;      nr.src_lo = c.src_addr_lo;
          nr.dst_hi = c.dst_addr_hi;      nr.dst_lo = c.dst_addr_lo;
          nr.src_len = c.src_prefix_len;  nr.dst_len = c.dst_prefix_len;
          nr.proto = c.protocol;
          nr.ports_en = c.flags[0];       nr.allow = c.flags[1];
          nr.src_ports = c.src_ports;     nr.dst_ports = c.dst_ports;
          acl_tbl[acl_count] = nr;
          acl_count++;
        end
      end
      OP_DELETE: begin
        if (c.rule_index >= acl_count) r.status = 1'b1;
        else begin
          for (int i = c.rule_index; i + 1 < acl_count; i++) acl_tbl[i] = acl_tbl[i + 1];
          acl_count--;
        end
      end
      default: acl_count = 0;
    endcase
    r.rules_held = acl_count[6:0];
    return r;
  endfunction

  // Driver
  bit drv_gap;
  always @(posedge clk_i) begin
    if (start && !busy) begin
      rsp_q.push_back(classify(req_i));
      void'(cmd_q.pop_front());
    end
    drv_gap = !quiet && ($urandom_range(99) < 14);
    if (cmd_q.size() > 0 && !drv_gap) begin
      start <= 1'b1;
      req_i <= cmd_q[0];
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor
  rsp_t want;
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (rsp_q.size() == 0) report_mismatch("unexpected beat", 1, 0);
      else begin
        want = rsp_q.pop_front();
        if (rsp_o.status !== want.status) report_mismatch("status", rsp_o.status, want.status);
        if (rsp_o.permit !== want.permit) report_mismatch("permit", rsp_o.permit, want.permit);
        if (rsp_o.deny_hit !== want.deny_hit)
          report_mismatch("deny_hit", rsp_o.deny_hit, want.deny_hit);
        if (rsp_o.deny_index !== want.deny_index)
          report_mismatch("deny_index", rsp_o.deny_index, want.deny_index);
        if (rsp_o.rules_held !== want.rules_held)
          report_mismatch("rules_held", rsp_o.rules_held, want.rules_held);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic req_t rand_req(input op_e op);
    req_t c;
    c.operation      = op;
    c.src_addr_hi    = rand64();
    c.src_addr_lo    = rand64();
    c.dst_addr_hi    = rand64();
    c.dst_addr_lo    = rand64();
    c.src_prefix_len = 8'($urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(128));
    c.dst_prefix_len = 8'($urandom_range(3) == 0 ? $urandom_range(255) : $urandom_range(128));
    c.protocol       = 8'($urandom());
    c.src_ports      = $urandom();
    c.dst_ports      = $urandom();
    c.flags          = 2'($urandom());
    c.rule_index     = 6'($urandom());
    return c;
  endfunction

  // Appended rules draw addresses from a small pool so packets hit them.
  logic [63:0] pool[4];

  function automatic req_t pool_req(input op_e op);
    req_t        c;
    logic [15:0] a, b;
    c = rand_req(op);
    c.src_addr_hi = pool[$urandom_range(3)];
    c.dst_addr_hi = pool[$urandom_range(3)];
    if ($urandom_range(1)) c.src_addr_lo = pool[$urandom_range(3)];
    if ($urandom_range(1)) c.dst_addr_lo = pool[$urandom_range(3)];
    if (op == OP_APPEND) begin
      c.src_prefix_len = 8'($urandom_range(4) * 32);
      c.dst_prefix_len = 8'($urandom_range(3) == 0 ? $urandom_range(129)
                                                   : $urandom_range(4) * 32);
      c.protocol = $urandom_range(2) == 0 ? 8'd0 : $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
      a = $urandom_range(3) == 0 ? 16'd0 : 16'($urandom());
      b = $urandom_range(3) == 0 ? 16'hffff : 16'($urandom());
      c.src_ports = $urandom_range(1) ? {a, b} : {16'd0, 16'hffff};
      a = 16'($urandom());
      b = 16'($urandom());
      c.dst_ports = {(a < b) ? a : b, (a < b) ? b : a};
    end else begin
      c.protocol = $urandom_range(3) == 0 ? 8'($urandom())
                 : $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
    end
    return c;
  endfunction

  task automatic wait_idle();
    while (cmd_q.size() > 0 || rsp_q.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [6:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    acl_limit = v;
  endtask

  initial begin
    req_t         c;
    int           r;
    logic [6:0]   limits[6];
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    n_errors    = 0;
    acl_count   = 0;
    acl_limit   = 7'd64;
    quiet       = 0;
    foreach (pool[i]) pool[i] = rand64();
    pool[0] = '0;
    pool[1] = '1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, bad deletes, field extremes, each operation.
    c = rand_req(OP_CHECK);  cmd_q.push_back(c);
    c = rand_req(OP_DELETE); c.rule_index = 6'd0;  cmd_q.push_back(c);
    c = '0; c.operation = OP_APPEND; cmd_q.push_back(c);            // match-all deny
    c = '0; c.operation = OP_CHECK; cmd_q.push_back(c);
    c = '1; c.operation = OP_CHECK; cmd_q.push_back(c);
    c = '1; c.operation = OP_APPEND; cmd_q.push_back(c);            // prefix 255, allow
    c = '1; c.operation = OP_CHECK; c.flags = 2'b01; c.protocol = PROTO_UDP; cmd_q.push_back(c);
    c = '0; c.operation = OP_APPEND; c.flags = 2'b01; c.protocol = PROTO_TCP;
    c.src_ports = {16'd10, 16'd20}; c.dst_ports = 32'h0000ffff; cmd_q.push_back(c);
    c = '0; c.operation = OP_CHECK; c.protocol = PROTO_TCP; c.flags = 2'b01;
    c.src_ports = 32'd15; cmd_q.push_back(c);
    c.src_ports = 32'd21; cmd_q.push_back(c);
    c.flags = 2'b00; cmd_q.push_back(c);                              // no L4: ports 0
    c = '0; c.operation = OP_DELETE; c.rule_index = 6'd63; cmd_q.push_back(c);
    c.rule_index = 6'd0; cmd_q.push_back(c);
    c = '0; c.operation = OP_CHECK; cmd_q.push_back(c);
    c = '0; c.operation = OP_CLEAR; cmd_q.push_back(c);
    c = '1; c.operation = OP_CLEAR; cmd_q.push_back(c);
    wait_idle();

    // Capacity extremes: 0, 1, 64, and above 64.
    limits = '{7'd0, 7'd1, 7'd127, 7'd5, 7'd64, 7'd100};
    for (int ph = 0; ph < 6; ph++) begin
      set_limit(limits[ph]);
      quiet = (ph == 4);
      c = '0; c.operation = OP_CLEAR; cmd_q.push_back(c);
      for (int k = 0; k < 215; k++) begin
        r = $urandom_range(99);
        if (r < 10) c = rand_req(op_e'($urandom_range(3)));
        else if (r < 45) c = pool_req(OP_APPEND);
        else if (r < 55) begin
          c = rand_req(OP_DELETE);
          if ($urandom_range(3) != 0 && acl_count > 0) c.rule_index = 6'($urandom_range(acl_count));
        end else if (r < 57) c = rand_req(OP_CLEAR);
        else c = pool_req(OP_CHECK);
        cmd_q.push_back(c);
        while (cmd_q.size() > 4) @(posedge clk_i);
      end
      // fill to the top for the full-table error path
      for (int k = 0; k < 70 && ph == 4; k++) cmd_q.push_back(pool_req(OP_APPEND));
      for (int k = 0; k < 10; k++) cmd_q.push_back(pool_req(OP_CHECK));
      wait_idle();
    end

    if (n_errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #50ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
